[design/bsa_pkg.sv]
// ----------------------------------------------------------------------------
// bsa_pkg: shared definitions for the bitmap slot allocator
// Pool geometry, opcodes, payload types and small bitmap helper functions.
// ----------------------------------------------------------------------------
package bsa_pkg;

	// pool geometry
	localparam int SLOT_COUNT = 1024;
	localparam int WORD_BITS  = 32;
	localparam int MAP_WORDS  = (SLOT_COUNT + WORD_BITS - 1) / WORD_BITS;
	localparam int WORD_AW    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int BIT_AW     = $clog2(WORD_BITS);

	// payload widths fixed by the transaction format
	localparam int OP_W    = 2;
	localparam int SLOT_W  = 11;
	localparam int COUNT_W = 11;

	// opcodes
	localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
	localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
	localparam logic [OP_W-1:0] OP_NEXT  = 2'd2;
	localparam logic [OP_W-1:0] OP_TEST  = 2'd3;

	typedef logic [OP_W-1:0]           opcode_t;
	typedef logic signed [SLOT_W-1:0]  slot_t;
	typedef logic [COUNT_W-1:0]        count_t;
	typedef logic [WORD_BITS-1:0]      map_word_t;
	typedef logic [WORD_AW-1:0]        word_addr_t;
	typedef logic [BIT_AW-1:0]         bit_pos_t;

	// result of a lowest-set-bit search
	typedef struct packed {
		logic     hit;
		bit_pos_t pos;
	} lsb_t;

	// priority encoder: lowest set bit of a bitmap word
	function automatic lsb_t lowest_set(input map_word_t w);
		lsb_t r;
		r.hit = 1'b0;
		r.pos = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (w[i]) begin
				r.hit = 1'b1;
				r.pos = BIT_AW'(i);
			end
		end
		return r;
	endfunction

	// bits of a word that map onto real slots of the pool
	function automatic map_word_t tail_mask(input word_addr_t wa);
		map_word_t m;
		for (int i = 0; i < WORD_BITS; i++) begin
			m[i] = ((int'(wa) * WORD_BITS + i) < SLOT_COUNT);
		end
		return m;
	endfunction

endpackage

[design/bsa_req_if.sv]
// ----------------------------------------------------------------------------
// bsa_req_if: request channel of the bitmap slot allocator
// Valid/ready channel carrying an opcode and a slot index.
// ----------------------------------------------------------------------------
interface bsa_req_if;
	import bsa_pkg::*;

	logic    valid;
	logic    ready;
	opcode_t opcode;
	slot_t   slot_index;

	modport source (output valid, output opcode, output slot_index, input ready);
	modport sink   (input valid, input opcode, input slot_index, output ready);

endinterface

[design/bsa_rsp_if.sv]
// ----------------------------------------------------------------------------
// bsa_rsp_if: response channel of the bitmap slot allocator
// Valid/ready channel carrying the slot result, flags and occupancy count.
// ----------------------------------------------------------------------------
interface bsa_rsp_if;
	import bsa_pkg::*;

	logic   valid;
	logic   ready;
	slot_t  result_slot;
	logic   success;
	logic   was_occupied;
	count_t occupied_count;

	modport source (output valid, output result_slot, output success,
		output was_occupied, output occupied_count, input ready);
	modport sink   (input valid, input result_slot, input success,
		input was_occupied, input occupied_count, output ready);

endinterface

[design/bitmap_slot_allocator.sv]
// ----------------------------------------------------------------------------
// bitmap_slot_allocator: fixed pool of slots tracked by an occupancy bitmap
// Alloc claims the lowest free slot, free releases one, next finds the first
// occupied slot above an index, test reports occupancy of one slot.
// ----------------------------------------------------------------------------
//
//  channel  modport  carries
//  -------  -------  ---------------------------------------------------------
//  req      sink     opcode, slot_index
//  rsp      source   result_slot, success, was_occupied, occupied_count
//
// Free and test pass through accept, index word read and response.
// Alloc and next add a scan of k bitmap words (1 to MAP_WORDS) read from the
// map memory, one word per cycle;
// next with a start past the last slot skips the scan.
// One transaction is in flight at a time; req.ready is high only when idle,
// and the response waits while rsp.ready stays low.
// Reset clears the per-word valid bits at once, so all slots read as free
// with no clearing pass. The response is held in registers until taken.
//
module bitmap_slot_allocator (
	input  logic        clk,
	input  logic        arst_n,
	bsa_req_if.sink     req,
	bsa_rsp_if.source   rsp
);
	import bsa_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_IDX  = 2'd1;
	localparam logic [1:0] S_SCAN = 2'd2;
	localparam logic [1:0] S_OUT  = 2'd3;

	localparam word_addr_t LAST_WORD = WORD_AW'(MAP_WORDS - 1);

	// map memory and per-word valid bits
	map_word_t            mem_q [MAP_WORDS];
	logic [MAP_WORDS-1:0] vld_q;
	map_word_t            rd_data_q;
	logic                 rd_vld_q;

	logic [1:0] state_q, state_d;
	opcode_t    op_q, op_d;
	slot_t      idx_q, idx_d;
	word_addr_t scan_word_q, scan_word_d;
	map_word_t  scan_mask_q, scan_mask_d;
	logic       was_q, was_d;
	slot_t      res_slot_q, res_slot_d;
	logic       success_q, success_d;
	count_t     count_q, count_d;

	logic       rd_en, wr_en;
	word_addr_t rd_addr, wr_addr;
	map_word_t  wr_data;

	map_word_t           word_eff;
	logic                idx_ok;
	bit_pos_t            idx_bit;
	logic [SLOT_W-1:0]   start;
	logic                start_ok;
	map_word_t           cand;
	lsb_t                lsb;

	// memory word as seen after reset clearing
	assign word_eff = rd_vld_q ? rd_data_q : '0;

	// request index decode
	assign idx_ok   = !idx_q[SLOT_W-1] && ($unsigned(idx_q) < SLOT_W'(SLOT_COUNT));
	assign idx_bit  = idx_q[BIT_AW-1:0];
	assign start    = idx_q[SLOT_W-1] ? '0 : ($unsigned(idx_q) + SLOT_W'(1));
	assign start_ok = (start < SLOT_W'(SLOT_COUNT));

	// scan candidates: free bits for alloc, occupied bits for next
	assign cand = (op_q == OP_ALLOC) ? (~word_eff & tail_mask(scan_word_q))
		: (word_eff & scan_mask_q & tail_mask(scan_word_q));
	assign lsb  = lowest_set(cand);

	// sequencer
	always_comb begin
		state_d     = state_q;
		op_d        = op_q;
		idx_d       = idx_q;
		scan_word_d = scan_word_q;
		scan_mask_d = scan_mask_q;
		was_d       = was_q;
		res_slot_d  = res_slot_q;
		success_d   = success_q;
		count_d     = count_q;
		rd_en       = 1'b0;
		rd_addr     = scan_word_q;
		wr_en       = 1'b0;
		wr_addr     = scan_word_q;
		wr_data     = word_eff;

		case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					op_d       = req.opcode;
					idx_d      = req.slot_index;
					res_slot_d = '1;
					success_d  = 1'b0;
					rd_en      = 1'b1;
					rd_addr    = req.slot_index[BIT_AW +: WORD_AW];
					state_d    = S_IDX;
				end
			end
			S_IDX: begin
				was_d   = idx_ok && word_eff[idx_bit];
				state_d = S_OUT;
				case (op_q)
					OP_FREE: begin
						if (was_d) begin
							wr_en      = 1'b1;
							wr_addr    = idx_q[BIT_AW +: WORD_AW];
							wr_data    = word_eff & ~(map_word_t'(1) << idx_bit);
							count_d    = count_q - COUNT_W'(1);
							res_slot_d = idx_q;
							success_d  = 1'b1;
						end
					end
					OP_TEST: begin
						if (was_d) begin
							res_slot_d = idx_q;
							success_d  = 1'b1;
						end
					end
					OP_ALLOC: begin
						scan_word_d = '0;
						scan_mask_d = '1;
						rd_en       = 1'b1;
						rd_addr     = '0;
						state_d     = S_SCAN;
					end
					OP_NEXT: begin
						if (start_ok) begin
							scan_word_d = start[BIT_AW +: WORD_AW];
							scan_mask_d = '1 << start[BIT_AW-1:0];
							rd_en       = 1'b1;
							rd_addr     = start[BIT_AW +: WORD_AW];
							state_d     = S_SCAN;
						end
					end
					default: begin
						state_d = S_OUT;
					end
				endcase
			end
			S_SCAN: begin
				if (lsb.hit) begin
					res_slot_d = slot_t'({scan_word_q, lsb.pos});
					success_d  = 1'b1;
					state_d    = S_OUT;
					if (op_q == OP_ALLOC) begin
						wr_en   = 1'b1;
						wr_data = word_eff | (map_word_t'(1) << lsb.pos);
						count_d = count_q + COUNT_W'(1);
					end
				end else if (scan_word_q == LAST_WORD) begin
					state_d = S_OUT;
				end else begin
					scan_word_d = scan_word_q + WORD_AW'(1);
					scan_mask_d = '1;
					rd_en       = 1'b1;
					rd_addr     = scan_word_q + WORD_AW'(1);
				end
			end
			S_OUT: begin
				if (rsp.ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// map memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	// valid bits and registered valid of the read word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	// transaction payload
	always_ff @(posedge clk) begin
		op_q        <= op_d;
		idx_q       <= idx_d;
		scan_word_q <= scan_word_d;
		scan_mask_q <= scan_mask_d;
		was_q       <= was_d;
		res_slot_q  <= res_slot_d;
		success_q   <= success_d;
	end

	// channel outputs
	assign req.ready          = (state_q == S_IDLE);
	assign rsp.valid          = (state_q == S_OUT);
	assign rsp.result_slot    = res_slot_q;
	assign rsp.success        = success_q;
	assign rsp.was_occupied   = was_q;
	assign rsp.occupied_count = count_q;

endmodule
